### hdl/cpu6502_pkg.sv
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Operation codes, flag positions and item layouts for the 6502 execute
// subset.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

    // operation codes carried in the mode field
    localparam logic [4:0] OP_ADC = 5'd0;
    localparam logic [4:0] OP_AND = 5'd1;
    localparam logic [4:0] OP_ASL_MEM = 5'd2;
    localparam logic [4:0] OP_ASL_ACC = 5'd3;
    localparam logic [4:0] OP_BCC = 5'd4;
    localparam logic [4:0] OP_BCS = 5'd5;
    localparam logic [4:0] OP_BEQ = 5'd6;
    localparam logic [4:0] OP_BMI = 5'd7;
    localparam logic [4:0] OP_BNE = 5'd8;
    localparam logic [4:0] OP_BPL = 5'd9;
    localparam logic [4:0] OP_BVC = 5'd10;
    localparam logic [4:0] OP_BVS = 5'd11;
    localparam logic [4:0] OP_BIT = 5'd12;
    localparam logic [4:0] OP_CLC = 5'd13;
    localparam logic [4:0] OP_CLD = 5'd14;
    localparam logic [4:0] OP_CLI = 5'd15;
    localparam logic [4:0] OP_CLV = 5'd16;
    localparam logic [4:0] OP_CMP = 5'd17;
    localparam logic [4:0] OP_CPX = 5'd18;
    localparam logic [4:0] OP_CPY = 5'd19;
    localparam logic [4:0] OP_DEC = 5'd20;
    localparam logic [4:0] OP_DEX = 5'd21;
    localparam logic [4:0] OP_DEY = 5'd22;
    localparam logic [4:0] OP_EOR = 5'd23;
    localparam logic [4:0] OP_INC = 5'd24;
    localparam logic [4:0] OP_INX = 5'd25;
    localparam logic [4:0] OP_INY = 5'd26;
    localparam logic [4:0] OP_LDA = 5'd27;
    localparam logic [4:0] OP_LDX = 5'd28;
    localparam logic [4:0] OP_LDY = 5'd29;

    // status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 80;

    typedef struct packed {
        logic [15:0] pc_in;
        logic [15:0] address;
        logic [7:0]  operand;
        logic [4:0]  mode;
    } in_item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        branch_taken;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic        mem_we;
        logic [7:0]  status_out;
        logic [7:0]  y_out;
        logic [7:0]  x_out;
        logic [7:0]  acc_out;
    } out_item_t;

endpackage

### hdl/cpu6502_execute_subset.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_subset
// Execute stage of a 6502 core: keeps A, X, Y and P, runs one operation per
// item and reports registers, memory write-back and branch decision.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  -------   ---   ----------------   -----------------------------------------
//  s_*       in    s_tvalid/s_tready  mode, operand, address, pc_in (48 bits)
//  m_*       out   m_tvalid/m_tready  acc, x, y, status, write, branch (80 bits)
//
//  One item per cycle sustained while m_tready keeps the result register
//  draining. An accepted item sits in the input register, is executed
//  against A/X/Y/P by one 8-bit add/compare level plus the 16-bit branch
//  adder, and lands in the result register, from which it is offered.
//  A/X/Y/P update as the item moves into the result register, so the next
//  item sees them at once.
//  rst_n clears A, X, Y, P and both valid flags. A stall on m_tready holds
//  the result; the input register still takes one more item before
//  s_tready drops.
//
module cpu6502_execute_subset
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] mode, [12:5] operand, [28:13] address, [44:29] pc_in, [47:45] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] acc_out, [15:8] x_out, [23:16] y_out, [31:24] status_out,
    // [32] mem_we, [40:33] mem_data, [56:41] mem_addr, [57] branch_taken,
    // [73:58] next_pc, [79:74] zero
    output logic [79:0] m_tdata
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    cpu6502_pkg::in_item_t in_item_reg;
    logic                  out_valid_reg;
    cpu6502_pkg::out_item_t out_item_reg;
    cpu6502_pkg::out_item_t out_item_next;
    logic                  out_load;
    logic                  advance;

    // result register free, or being emptied this cycle
    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= cpu6502_pkg::in_item_t'(s_tdata[44:0]);
        end
    end

    // ------------------------------------------------------------------
    // Architectural registers
    // ------------------------------------------------------------------
    logic [7:0] acc_reg, acc_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] status_reg, status_next;

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic [7:0]  m;
    logic [8:0]  adc_sum;
    logic [7:0]  cmp_reg;
    logic [8:0]  cmp_diff;
    logic [7:0]  zn_val;
    logic        zn_upd;
    logic        we;
    logic [7:0]  wdata;
    logic        taken;
    logic [15:0] branch_pc;

    assign m       = in_item_reg.operand;
    assign adc_sum = {1'b0, acc_reg} + {1'b0, m}
                   + {8'd0, status_reg[cpu6502_pkg::FLAG_C]};
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
    assign branch_pc = in_item_reg.pc_in + {{8{m[7]}}, m};

    always_comb
    begin
        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        status_next = status_reg;
        zn_val      = 8'd0;
        zn_upd      = 1'b0;
        we          = 1'b0;
        wdata       = 8'd0;
        taken       = 1'b0;
        cmp_reg     = acc_reg;

        unique case (in_item_reg.mode)
            cpu6502_pkg::OP_ADC:
            begin
                acc_next = adc_sum[7:0];
                status_next[cpu6502_pkg::FLAG_C] = adc_sum[8];
                status_next[cpu6502_pkg::FLAG_V] =
                    (adc_sum[7] ^ acc_reg[7]) & (adc_sum[7] ^ m[7]);
                zn_val = adc_sum[7:0];
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_AND:
            begin
                acc_next = acc_reg & m;
                zn_val   = acc_reg & m;
                zn_upd   = 1'b1;
            end
            cpu6502_pkg::OP_ASL_MEM:
            begin
                status_next[cpu6502_pkg::FLAG_C] = m[7];
                zn_val = {m[6:0], 1'b0};
                zn_upd = 1'b1;
                we     = 1'b1;
                wdata  = {m[6:0], 1'b0};
            end
            cpu6502_pkg::OP_ASL_ACC:
            begin
                status_next[cpu6502_pkg::FLAG_C] = m[7];
                zn_val   = {m[6:0], 1'b0};
                zn_upd   = 1'b1;
                acc_next = {m[6:0], 1'b0};
            end
            cpu6502_pkg::OP_BCC: taken = !status_reg[cpu6502_pkg::FLAG_C];
            cpu6502_pkg::OP_BCS: taken = status_reg[cpu6502_pkg::FLAG_C];
            cpu6502_pkg::OP_BEQ: taken = status_reg[cpu6502_pkg::FLAG_Z];
            cpu6502_pkg::OP_BMI: taken = status_reg[cpu6502_pkg::FLAG_N];
            cpu6502_pkg::OP_BNE: taken = !status_reg[cpu6502_pkg::FLAG_Z];
            cpu6502_pkg::OP_BPL: taken = !status_reg[cpu6502_pkg::FLAG_N];
            cpu6502_pkg::OP_BVC: taken = !status_reg[cpu6502_pkg::FLAG_V];
            cpu6502_pkg::OP_BVS: taken = status_reg[cpu6502_pkg::FLAG_V];
            cpu6502_pkg::OP_BIT:
            begin
                status_next[cpu6502_pkg::FLAG_Z] = ((acc_reg & m) == 8'd0);
                status_next[cpu6502_pkg::FLAG_V] = m[6];
                status_next[cpu6502_pkg::FLAG_N] = m[7];
            end
            cpu6502_pkg::OP_CLC: status_next[cpu6502_pkg::FLAG_C] = 1'b0;
            cpu6502_pkg::OP_CLD: status_next[cpu6502_pkg::FLAG_D] = 1'b0;
            cpu6502_pkg::OP_CLI: status_next[cpu6502_pkg::FLAG_I] = 1'b0;
            cpu6502_pkg::OP_CLV: status_next[cpu6502_pkg::FLAG_V] = 1'b0;
            cpu6502_pkg::OP_CMP, cpu6502_pkg::OP_CPX, cpu6502_pkg::OP_CPY:
            begin
                if (in_item_reg.mode == cpu6502_pkg::OP_CPX)
                begin
                    cmp_reg = x_reg;
                end
                else if (in_item_reg.mode == cpu6502_pkg::OP_CPY)
                begin
                    cmp_reg = y_reg;
                end
                // no borrow means register >= operand
                status_next[cpu6502_pkg::FLAG_C] = !cmp_diff[8];
                zn_val = cmp_diff[7:0];
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_DEC:
            begin
                zn_val = m - 8'd1;
                zn_upd = 1'b1;
                we     = 1'b1;
                wdata  = m - 8'd1;
            end
            cpu6502_pkg::OP_DEX:
            begin
                x_next = x_reg - 8'd1;
                zn_val = x_reg - 8'd1;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_DEY:
            begin
                y_next = y_reg - 8'd1;
                zn_val = y_reg - 8'd1;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_EOR:
            begin
                acc_next = acc_reg ^ m;
                zn_val   = acc_reg ^ m;
                zn_upd   = 1'b1;
            end
            cpu6502_pkg::OP_INC:
            begin
                zn_val = m + 8'd1;
                zn_upd = 1'b1;
                we     = 1'b1;
                wdata  = m + 8'd1;
            end
            cpu6502_pkg::OP_INX:
            begin
                x_next = x_reg + 8'd1;
                zn_val = x_reg + 8'd1;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_INY:
            begin
                y_next = y_reg + 8'd1;
                zn_val = y_reg + 8'd1;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_LDA:
            begin
                acc_next = m;
                zn_val   = m;
                zn_upd   = 1'b1;
            end
            cpu6502_pkg::OP_LDX:
            begin
                x_next = m;
                zn_val = m;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_LDY:
            begin
                y_next = m;
                zn_val = m;
                zn_upd = 1'b1;
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase

        if (zn_upd)
        begin
            status_next[cpu6502_pkg::FLAG_Z] = (zn_val == 8'd0);
            status_next[cpu6502_pkg::FLAG_N] = zn_val[7];
        end
    end

    always_comb
    begin
        out_item_next.acc_out      = acc_next;
        out_item_next.x_out        = x_next;
        out_item_next.y_out        = y_next;
        out_item_next.status_out   = status_next;
        out_item_next.mem_we       = we;
        out_item_next.mem_data     = wdata;
        out_item_next.mem_addr     = we ? in_item_reg.address : 16'd0;
        out_item_next.branch_taken = taken;
        out_item_next.next_pc      = taken ? branch_pc : in_item_reg.pc_in;
    end

    // commit state as the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= 8'd0;
            x_reg      <= 8'd0;
            y_reg      <= 8'd0;
            status_reg <= 8'd0;
        end
        else if (advance)
        begin
            acc_reg    <= acc_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            status_reg <= status_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_item_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_no_branch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.mem_we |-> !out_item_reg.branch_taken)
        else $error("memory write and branch in the same item");

    a_no_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.mem_we |->
            out_item_reg.mem_data == 8'd0 && out_item_reg.mem_addr == 16'd0)
        else $error("write fields not cleared without a write");

    a_unused_flags: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[5:4] == 2'b00)
        else $error("unused status bits changed");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while a stage was free");

    a_state_commit: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> acc_reg == out_item_reg.acc_out
            && status_reg == out_item_reg.status_out)
        else $error("state and result register disagree");

endmodule

### tb/cpu6502_execute_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu6502_execute_checker
// Watches both stream channels of the execute stage, keeps its own A, X, Y
// and P, predicts one result per accepted item and compares every field.
// ----------------------------------------------------------------------------
module cpu6502_execute_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [4:0] mode, [12:5] operand, [28:13] address, [44:29] pc_in, [47:45] zero
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] acc_out, [15:8] x_out, [23:16] y_out, [31:24] status_out,
    // [32] mem_we, [40:33] mem_data, [56:41] mem_addr, [57] branch_taken,
    // [73:58] next_pc, [79:74] zero
    input  logic [79:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          branches
);

    logic [7:0] acc_r;
    logic [7:0] x_r;
    logic [7:0] y_r;
    logic [7:0] p_r;
    cpu6502_pkg::out_item_t outcome_q[$];
    int         err_n = 0;
    int         chk_n = 0;
    int         br_n = 0;

    // run one operation against the shadow registers
    task automatic execute_op(input cpu6502_pkg::in_item_t it,
                              output cpu6502_pkg::out_item_t res);
        logic [8:0] sum;
        logic [7:0] m;
        logic [7:0] r;
        logic [7:0] cmp_reg;
        logic [7:0] zn_val;
        logic       zn_upd;
        logic       taken;
        logic       we;
        m = it.operand;
        r = 8'h00;
        zn_val = 8'h00;
        zn_upd = 1'b0;
        taken = 1'b0;
        we = 1'b0;
        case (it.mode)
            cpu6502_pkg::OP_ADC:
            begin
                sum = {1'b0, acc_r} + {1'b0, m} + {8'h00, p_r[cpu6502_pkg::FLAG_C]};
                r = sum[7:0];
                p_r[cpu6502_pkg::FLAG_C] = sum[8];
                p_r[cpu6502_pkg::FLAG_V] = (r[7] ^ acc_r[7]) & (r[7] ^ m[7]);
                acc_r = r;
                zn_val = r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_AND:
            begin
                acc_r = acc_r & m;
                zn_val = acc_r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_ASL_MEM, cpu6502_pkg::OP_ASL_ACC:
            begin
                // both forms shift the fetched byte
                r = {m[6:0], 1'b0};
                p_r[cpu6502_pkg::FLAG_C] = m[7];
                zn_val = r;
                zn_upd = 1'b1;
                if (it.mode == cpu6502_pkg::OP_ASL_ACC)
                    acc_r = r;
                else
                    we = 1'b1;
            end
            cpu6502_pkg::OP_BCC: taken = !p_r[cpu6502_pkg::FLAG_C];
            cpu6502_pkg::OP_BCS: taken = p_r[cpu6502_pkg::FLAG_C];
            cpu6502_pkg::OP_BEQ: taken = p_r[cpu6502_pkg::FLAG_Z];
            cpu6502_pkg::OP_BMI: taken = p_r[cpu6502_pkg::FLAG_N];
            cpu6502_pkg::OP_BNE: taken = !p_r[cpu6502_pkg::FLAG_Z];
            cpu6502_pkg::OP_BPL: taken = !p_r[cpu6502_pkg::FLAG_N];
            cpu6502_pkg::OP_BVC: taken = !p_r[cpu6502_pkg::FLAG_V];
            cpu6502_pkg::OP_BVS: taken = p_r[cpu6502_pkg::FLAG_V];
            cpu6502_pkg::OP_BIT:
            begin
                p_r[cpu6502_pkg::FLAG_Z] = ((acc_r & m) == 8'h00);
                p_r[cpu6502_pkg::FLAG_V] = m[6];
                p_r[cpu6502_pkg::FLAG_N] = m[7];
            end
            cpu6502_pkg::OP_CLC: p_r[cpu6502_pkg::FLAG_C] = 1'b0;
            cpu6502_pkg::OP_CLD: p_r[cpu6502_pkg::FLAG_D] = 1'b0;
            cpu6502_pkg::OP_CLI: p_r[cpu6502_pkg::FLAG_I] = 1'b0;
            cpu6502_pkg::OP_CLV: p_r[cpu6502_pkg::FLAG_V] = 1'b0;
            cpu6502_pkg::OP_CMP, cpu6502_pkg::OP_CPX, cpu6502_pkg::OP_CPY:
            begin
                cmp_reg = (it.mode == cpu6502_pkg::OP_CMP) ? acc_r :
                          (it.mode == cpu6502_pkg::OP_CPX) ? x_r : y_r;
                p_r[cpu6502_pkg::FLAG_C] = (cmp_reg >= m);
                zn_val = cmp_reg - m;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_DEC:
            begin
                r = m - 8'h01;
                we = 1'b1;
                zn_val = r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_INC:
            begin
                r = m + 8'h01;
                we = 1'b1;
                zn_val = r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_DEX:
            begin
                x_r = x_r - 8'h01;
                zn_val = x_r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_DEY:
            begin
                y_r = y_r - 8'h01;
                zn_val = y_r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_INX:
            begin
                x_r = x_r + 8'h01;
                zn_val = x_r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_INY:
            begin
                y_r = y_r + 8'h01;
                zn_val = y_r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_EOR:
            begin
                acc_r = acc_r ^ m;
                zn_val = acc_r;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_LDA:
            begin
                acc_r = m;
                zn_val = m;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_LDX:
            begin
                x_r = m;
                zn_val = m;
                zn_upd = 1'b1;
            end
            cpu6502_pkg::OP_LDY:
            begin
                y_r = m;
                zn_val = m;
                zn_upd = 1'b1;
            end
            default: ;
        endcase
        if (zn_upd)
        begin
            p_r[cpu6502_pkg::FLAG_Z] = (zn_val == 8'h00);
            p_r[cpu6502_pkg::FLAG_N] = zn_val[7];
        end
        res.acc_out = acc_r;
        res.x_out = x_r;
        res.y_out = y_r;
        res.status_out = p_r;
        res.mem_we = we;
        res.mem_data = we ? r : 8'h00;
        res.mem_addr = we ? it.address : 16'h0000;
        res.branch_taken = taken;
        res.next_pc = taken ? it.pc_in + {{8{m[7]}}, m} : it.pc_in;
    endtask

    function automatic int field_bad(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cpu6502_pkg::out_item_t want;
        cpu6502_pkg::out_item_t got;
        cpu6502_pkg::in_item_t  it;
        if (!rst_n)
        begin
            acc_r = 8'h00;
            x_r = 8'h00;
            y_r = 8'h00;
            p_r = 8'h00;
            outcome_q.delete();
        end
        else
        begin
            // drain the result side first; latency keeps it behind the input
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(cpu6502_pkg::out_item_t)-1:0];
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    err_n = err_n + 1;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    err_n = err_n + field_bad("acc_out", 16'(want.acc_out),
                                              16'(got.acc_out));
                    err_n = err_n + field_bad("x_out", 16'(want.x_out), 16'(got.x_out));
                    err_n = err_n + field_bad("y_out", 16'(want.y_out), 16'(got.y_out));
                    err_n = err_n + field_bad("status_out", 16'(want.status_out),
                                              16'(got.status_out));
                    err_n = err_n + field_bad("mem_we", 16'(want.mem_we), 16'(got.mem_we));
                    err_n = err_n + field_bad("mem_data", 16'(want.mem_data),
                                              16'(got.mem_data));
                    err_n = err_n + field_bad("mem_addr", want.mem_addr, got.mem_addr);
                    err_n = err_n + field_bad("branch_taken", 16'(want.branch_taken),
                                              16'(got.branch_taken));
                    err_n = err_n + field_bad("next_pc", want.next_pc, got.next_pc);
                    chk_n = chk_n + 1;
                    if (want.branch_taken)
                        br_n = br_n + 1;
                end
            end
            if (s_tvalid && s_tready)
            begin
                it = s_tdata[$bits(cpu6502_pkg::in_item_t)-1:0];
                execute_op(it, want);
                outcome_q.push_back(want);
            end
        end
        fail_count <= err_n;
        pending <= outcome_q.size();
        checked <= chk_n;
        branches <= br_n;
    end

endmodule

### tb/tb_cpu6502_execute_subset.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu6502_execute_subset
// Drives instruction items into the execute stage with random gaps, takes
// results with random stalls and one long hold-off, and lets the checker
// compare every result against its own model of A, X, Y and P.
// ----------------------------------------------------------------------------
module tb_cpu6502_execute_subset;

    // mode values the block leaves unassigned; they must change nothing
    localparam logic [4:0] OP_SPARE_A = 5'd30;
    localparam logic [4:0] OP_SPARE_B = 5'd31;

    localparam int GAP_MAX = 16;       // longest per-item wait on either side
    localparam int PHASE_LEN = 40;     // items per traffic phase
    localparam int RANDOM_ITEMS = 420;
    localparam int PRESSURE_AT = 150;  // result count that triggers the hold-off
    localparam int STALL_LONG = 80;    // hold-off length, far beyond the buffering
    localparam int TAIL_CYCLES = 8;    // quiet tail after draining, for stray results
    localparam int IDLE_LIMIT = 1000;  // cycles without any handshake

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int branches;
    int sent = 0;
    int received = 0;
    int directed_n = 0;
    int idle_cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    cpu6502_execute_subset dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cpu6502_execute_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .branches   (branches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item after a random gap and hold it until the block takes it.
    // Lower tvalid only when a gap follows, so back-to-back items never see
    // tvalid dropped and raised in the same step.
    task automatic issue(input logic [4:0] op, input logic [7:0] opnd,
                         input logic [15:0] addr, input logic [15:0] pc);
        cpu6502_pkg::in_item_t it;
        int                    gap;
        it.mode = op;
        it.operand = opnd;
        it.address = addr;
        it.pc_in = pc;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(cpu6502_pkg::IN_TDATA_W - $bits(cpu6502_pkg::in_item_t)){1'b0}}, it};
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // bias bytes toward the sign and carry boundaries
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // weight branches up so every condition meets both flag values often
    function automatic logic [4:0] rand_op();
        case ($urandom_range(0, 15))
            0: return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
            1, 2, 3: return 5'($urandom_range(cpu6502_pkg::OP_BCC, cpu6502_pkg::OP_BVS));
            default: return 5'($urandom_range(cpu6502_pkg::OP_ADC, cpu6502_pkg::OP_LDY));
        endcase
    endfunction

    // stimulus and verdict
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every operation, branch wrap both ways
        issue(cpu6502_pkg::OP_LDA, 8'hFF, 16'hFFFF, 16'hFFFF);
        issue(cpu6502_pkg::OP_ADC, 8'h01, 16'h0000, 16'h0000);   // carry out, result zero
        issue(cpu6502_pkg::OP_BCS, 8'h01, 16'h0000, 16'hFFFF);   // taken, wraps to zero
        issue(cpu6502_pkg::OP_BEQ, 8'h80, 16'hFFFF, 16'h0000);   // taken, backward wrap
        issue(cpu6502_pkg::OP_LDA, 8'h7F, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_ADC, 8'h7F, 16'h0000, 16'h0000);   // carry in, signed overflow
        issue(cpu6502_pkg::OP_BVS, 8'h7F, 16'h0000, 16'h8000);
        issue(cpu6502_pkg::OP_BMI, 8'hFE, 16'h0000, 16'h0001);
        issue(cpu6502_pkg::OP_BCC, 8'h10, 16'h0000, 16'h7FFF);
        issue(cpu6502_pkg::OP_CLV, 8'h00, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_BVC, 8'h05, 16'h0000, 16'h0100);
        issue(cpu6502_pkg::OP_BPL, 8'h05, 16'h0000, 16'h0100);   // N set, falls through
        issue(cpu6502_pkg::OP_AND, 8'h80, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_BNE, 8'hF0, 16'h0000, 16'h0008);   // Z clear, taken
        issue(cpu6502_pkg::OP_ASL_ACC, 8'hC1, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_ASL_MEM, 8'h80, 16'hFFFF, 16'h0000);
        issue(cpu6502_pkg::OP_BIT, 8'hC0, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_CLC, 8'h00, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_CMP, 8'h82, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_DEX, 8'h00, 16'h0000, 16'h0000);   // X underflows
        issue(cpu6502_pkg::OP_CPX, 8'hFF, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_LDY, 8'hFF, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_INY, 8'h00, 16'h0000, 16'h0000);   // Y overflows to zero
        issue(cpu6502_pkg::OP_CPY, 8'h01, 16'h0000, 16'h0000);   // borrow
        issue(cpu6502_pkg::OP_DEY, 8'h00, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_INX, 8'h00, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_EOR, 8'hFF, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_INC, 8'hFF, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_DEC, 8'h00, 16'hFFFF, 16'h0000);
        issue(cpu6502_pkg::OP_LDX, 8'h80, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_CLD, 8'h00, 16'h0000, 16'h0000);
        issue(cpu6502_pkg::OP_CLI, 8'h00, 16'h0000, 16'h0000);
        issue(OP_SPARE_A, 8'hFF, 16'hFFFF, 16'hFFFF);
        issue(OP_SPARE_B, 8'h01, 16'h5555, 16'hAAAA);
        directed_n = sent;

        // random: each phase picks back-to-back items or random gaps
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
                tx_burst = ($urandom_range(0, 2) == 0);
            issue(rand_op(), rand_byte(), rand_word(), rand_word());
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for any stray result
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d instructions issued (%0d directed), %0d results checked",
                 sent, directed_n, checked);
        $display("Summary: %0d branches taken; output held off %0d cycles once",
                 branches, STALL_LONG);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Result side: random stall per item, stall-free phases, and one long
    // hold-off so the block backs up and drops s_tready.
    initial
    begin : receiver
        int stall;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (received == PRESSURE_AT)
            begin
                m_tready <= 1'b0;
                repeat (STALL_LONG) @(posedge clk);
            end
            stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            received++;
            if (received % PHASE_LEN == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog: any handshake resets the count of quiet cycles
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

### filelist.f
hdl/cpu6502_pkg.sv
hdl/cpu6502_execute_subset.sv
tb/cpu6502_execute_checker.sv
tb/tb_cpu6502_execute_subset.sv
